### rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, command codes and sequence lengths for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int PortWidth = 8;
    localparam int PinWidth  = 3;
    localparam int OpWidth   = 3;
    localparam int SlotWidth = 6;

    localparam logic [OpWidth-1:0] CMD_NONE  = 3'd0;
    localparam logic [OpWidth-1:0] CMD_START = 3'd1;
    localparam logic [OpWidth-1:0] CMD_STOP  = 3'd2;
    localparam logic [OpWidth-1:0] CMD_WRITE = 3'd3;
    localparam logic [OpWidth-1:0] CMD_READ  = 3'd4;

    localparam logic CFG_CLOCK_PIN = 1'b0;
    localparam logic CFG_DATA_PIN  = 1'b1;

    localparam logic [SlotWidth-1:0] WR_ACK_DATA   = 6'd32;
    localparam logic [SlotWidth-1:0] WR_ACK_CLOCK  = 6'd33;
    localparam logic [SlotWidth-1:0] WR_ACK_SAMPLE = 6'd34;
    localparam logic [SlotWidth-1:0] RD_LAST_BIT   = 6'd24;
    localparam logic [SlotWidth-1:0] RD_ACK_DATA   = 6'd25;
    localparam logic [SlotWidth-1:0] RD_ACK_CLOCK  = 6'd26;
    localparam logic [SlotWidth-1:0] RD_ACK_LOW    = 6'd28;
    localparam logic [SlotWidth-1:0] RD_RELEASE    = 6'd29;

    typedef struct packed {
        logic [OpWidth-1:0]   opcode;
        logic [PortWidth-1:0] tx_byte;
        logic                 ack_to_send;
        logic [PortWidth-1:0] port_in;
    } cmd_item_t;

    typedef struct packed {
        logic [PortWidth-1:0] port_out;
        logic                 busy_res;
        logic                 done_res;
        logic [PortWidth-1:0] rx_byte;
        logic                 ack_received;
    } res_item_t;

    // last slot index of each command
    function automatic logic [SlotWidth-1:0] last_slot(input logic [OpWidth-1:0] cmd);
        logic [SlotWidth-1:0] s;
        unique case (cmd)
            CMD_START: s = 6'd3;
            CMD_STOP:  s = 6'd2;
            CMD_WRITE: s = 6'd35;
            CMD_READ:  s = 6'd29;
            default:   s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

### rtl/i2cms_if.sv
// ----------------------------------------------------------------------------
// i2cms_cmd_if / i2cms_res_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
    logic                  valid;
    logic                  ready;
    i2cms_pkg::cmd_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_res_if;
    logic                  valid;
    logic                  ready;
    i2cms_pkg::res_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that drives SCL and SDA on two selectable bits of an 8-bit port.
//
// Each item on the cmd channel is one delay slot: it carries an optional
// command (start, stop, write byte, read byte), the byte to send, the ACK
// choice for a read and the sampled port pins. Every accepted item yields
// exactly one item on the res channel: port drive value, busy, done,
// received byte and ACK flag. Commands arriving while busy are ignored.
// The slot sequence itself is one tick per item: start 4, stop 3,
// write 36, read 30.
// Latency: the result of an item is presented the cycle after acceptance.
// Throughput: one item per cycle; the single result register is reloaded
// in the same cycle it is taken, so cmd.ready follows res.ready.
// When the receiver stalls, the result is held and cmd.ready drops until
// it is taken. Reset: lines released, idle, SCL on bit 0, SDA on bit 1,
// no result pending. cfg_we writes clock_pin (index 0) or data_pin (1).
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [i2cms_pkg::PinWidth-1:0] cfg_data,
    i2cms_cmd_if.sink                     cmd,
    i2cms_res_if.source                   res
);

    logic [i2cms_pkg::PinWidth-1:0]  clock_pin_reg;
    logic [i2cms_pkg::PinWidth-1:0]  data_pin_reg;
    logic                            clock_level_reg, clock_level_next;
    logic                            data_level_reg, data_level_next;
    logic [i2cms_pkg::OpWidth-1:0]   active_reg, active_next;
    logic [i2cms_pkg::SlotWidth-1:0] slot_reg, slot_next;
    logic [1:0]                      phase_reg, phase_next;
    logic [i2cms_pkg::PortWidth-1:0] shift_reg, shift_next;
    logic [i2cms_pkg::PortWidth-1:0] tx_reg, tx_next;
    logic                            ack_choice_reg, ack_choice_next;
    logic                            ack_flag_reg, ack_flag_next;
    logic                            res_valid_reg;
    i2cms_pkg::res_item_t            res_reg, res_next;

    logic                            accept;
    logic                            start;
    logic [i2cms_pkg::OpWidth-1:0]   op;
    logic [i2cms_pkg::OpWidth-1:0]   cmd_eff;
    logic [i2cms_pkg::SlotWidth-1:0] slot_eff;
    logic [1:0]                      phase_eff;
    logic                            sda_in;
    logic                            done;
    logic [i2cms_pkg::PortWidth-1:0] drive;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

    assign op     = cmd.data.opcode;
    assign sda_in = cmd.data.port_in[data_pin_reg];
    assign start  = (active_reg == i2cms_pkg::CMD_NONE) &&
                    (op == i2cms_pkg::CMD_START || op == i2cms_pkg::CMD_STOP ||
                     op == i2cms_pkg::CMD_WRITE || op == i2cms_pkg::CMD_READ);

    always_comb
    begin
        cmd_eff          = start ? op : active_reg;
        slot_eff         = start ? '0 : slot_reg;
        phase_eff        = start ? 2'd0 : phase_reg;
        tx_next          = (start && op == i2cms_pkg::CMD_WRITE) ? cmd.data.tx_byte : tx_reg;
        ack_choice_next  = (start && op == i2cms_pkg::CMD_READ) ? cmd.data.ack_to_send
                                                                 : ack_choice_reg;
        shift_next       = (start && op == i2cms_pkg::CMD_READ) ? '0 : shift_reg;
        clock_level_next = clock_level_reg;
        data_level_next  = data_level_reg;
        ack_flag_next    = ack_flag_reg;
        phase_next       = phase_eff;

        unique case (cmd_eff)
            i2cms_pkg::CMD_START:
            begin
                unique case (slot_eff[1:0])
                    2'd0:    clock_level_next = 1'b1;
                    2'd1:    data_level_next  = 1'b1;
                    2'd2:    data_level_next  = 1'b0;
                    default: clock_level_next = 1'b0;
                endcase
            end
            i2cms_pkg::CMD_STOP:
            begin
                unique case (slot_eff[1:0])
                    2'd0:    data_level_next  = 1'b0;
                    2'd1:    clock_level_next = 1'b1;
                    default: data_level_next  = 1'b1;
                endcase
            end
            i2cms_pkg::CMD_WRITE:
            begin
                if (slot_eff < i2cms_pkg::WR_ACK_DATA)
                begin
                    unique case (slot_eff[1:0])
                        2'd0:    data_level_next  = tx_next[~slot_eff[4:2]];
                        2'd1:    clock_level_next = 1'b1;
                        2'd2:    clock_level_next = clock_level_reg;
                        default: clock_level_next = 1'b0;
                    endcase
                end
                else if (slot_eff == i2cms_pkg::WR_ACK_DATA)
                    data_level_next = 1'b1;
                else if (slot_eff == i2cms_pkg::WR_ACK_CLOCK)
                    clock_level_next = 1'b1;
                else if (slot_eff == i2cms_pkg::WR_ACK_SAMPLE)
                    ack_flag_next = !sda_in;
                else
                    clock_level_next = 1'b0;
            end
            i2cms_pkg::CMD_READ:
            begin
                if (slot_eff == '0)
                    data_level_next = 1'b1;
                else if (slot_eff <= i2cms_pkg::RD_LAST_BIT)
                begin
                    // bit phase: clock high, sample, clock low
                    phase_next = (phase_eff == 2'd2) ? 2'd0 : phase_eff + 2'd1;
                    if (phase_eff == 2'd0)
                        clock_level_next = 1'b1;
                    else if (phase_eff == 2'd1)
                        shift_next = {shift_next[i2cms_pkg::PortWidth-2:0], sda_in};
                    else
                        clock_level_next = 1'b0;
                end
                else if (slot_eff == i2cms_pkg::RD_ACK_DATA)
                    data_level_next = !ack_choice_next;
                else if (slot_eff == i2cms_pkg::RD_ACK_CLOCK)
                    clock_level_next = 1'b1;
                else if (slot_eff == i2cms_pkg::RD_ACK_LOW)
                    clock_level_next = 1'b0;
                else if (slot_eff == i2cms_pkg::RD_RELEASE)
                    data_level_next = 1'b1;
            end
            default:
            begin
                clock_level_next = clock_level_reg;
            end
        endcase

        done = (cmd_eff != i2cms_pkg::CMD_NONE) &&
               (slot_eff == i2cms_pkg::last_slot(cmd_eff));
        if (cmd_eff == i2cms_pkg::CMD_NONE || done)
        begin
            active_next = i2cms_pkg::CMD_NONE;
            slot_next   = '0;
        end
        else
        begin
            active_next = cmd_eff;
            slot_next   = slot_eff + 6'd1;
        end

        drive = '1;
        if (!clock_level_next)
            drive[clock_pin_reg] = 1'b0;
        if (!data_level_next)
            drive[data_pin_reg] = 1'b0;

        res_next.port_out     = drive;
        res_next.busy_res     = (active_next != i2cms_pkg::CMD_NONE);
        res_next.done_res     = done;
        res_next.rx_byte      = shift_next;
        res_next.ack_received = ack_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_pin_reg   <= 3'd0;
            data_pin_reg    <= 3'd1;
            clock_level_reg <= 1'b1;
            data_level_reg  <= 1'b1;
            active_reg      <= i2cms_pkg::CMD_NONE;
            slot_reg        <= '0;
            phase_reg       <= 2'd0;
            shift_reg       <= '0;
            tx_reg          <= '0;
            ack_choice_reg  <= 1'b0;
            ack_flag_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == i2cms_pkg::CFG_CLOCK_PIN)
                    clock_pin_reg <= cfg_data;
                else
                    data_pin_reg <= cfg_data;
            end
            if (accept)
            begin
                clock_level_reg <= clock_level_next;
                data_level_reg  <= data_level_next;
                active_reg      <= active_next;
                slot_reg        <= slot_next;
                phase_reg       <= phase_next;
                shift_reg       <= shift_next;
                tx_reg          <= tx_next;
                ack_choice_reg  <= ack_choice_next;
                ack_flag_reg    <= ack_flag_next;
                res_valid_reg   <= 1'b1;
            end
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    // a finished command never reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done result still reports busy");

    // slot counter stays inside the running command
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg != i2cms_pkg::CMD_NONE |-> slot_reg <= i2cms_pkg::last_slot(active_reg))
        else $error("slot counter beyond command length");

    // idle sequencer keeps its slot counter cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == i2cms_pkg::CMD_NONE |-> slot_reg == '0)
        else $error("slot counter not cleared while idle");

    // read bit phase never reaches three
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("read bit phase out of range");

    // state only moves when an item is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> $stable(active_reg) && $stable(slot_reg))
        else $error("sequencer state changed without an item");

endmodule

### tb/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Drives tick items into the I2C bit sequencer and checks every result item
// against a tick-by-tick model of the line levels, status and shift state.
// Covers idle ticks, start, stop, byte write with ACK and NACK, byte read
// with ACK and NACK, commands while busy, pin selection including a shared
// pin, then long random command traffic with random stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb;

    import i2cms_pkg::*;

    localparam int ItemTarget = 700;
    localparam int CycleLimit = 400000;

    localparam logic [OpWidth-1:0] OP_UNUSED_FIRST = CMD_READ + 3'd1;
    localparam logic [OpWidth-1:0] OP_UNUSED_LAST  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [PinWidth-1:0] cfg_data;

    i2cms_cmd_if cmd_ch ();
    i2cms_res_if res_ch ();

    i2c_master_bit_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // model of the sequencer
    logic [PinWidth-1:0]  scl_pin;
    logic [PinWidth-1:0]  sda_pin;
    logic                 scl_level;
    logic                 sda_level;
    logic [OpWidth-1:0]   run_cmd;
    int unsigned          run_slot;
    logic [PortWidth-1:0] rx_shift;
    logic [PortWidth-1:0] tx_hold;
    logic                 ack_pick;
    logic                 ack_seen;

    res_item_t line_forecast[$];
    int        errors;
    int        ticks_sent;
    int        cycles;
    bit        steady;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int seq_length(input logic [OpWidth-1:0] op);
        case (op)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_WRITE: return 36;
            CMD_READ:  return 30;
            default:   return 0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic res_item_t predict_tick(input cmd_item_t it);
        res_item_t            r;
        int                   bitpos;
        int                   phase;
        logic [PortWidth-1:0] drive;
        r.done_res = 1'b0;
        if (run_cmd == CMD_NONE && it.opcode >= CMD_START && it.opcode <= CMD_READ)
        begin
            run_cmd  = it.opcode;
            run_slot = 0;
            if (it.opcode == CMD_WRITE)
                tx_hold = it.tx_byte;
            if (it.opcode == CMD_READ)
            begin
                ack_pick = it.ack_to_send;
                rx_shift = '0;
            end
        end
        if (run_cmd != CMD_NONE)
        begin
            case (run_cmd)
                CMD_START:
                begin
                    if (run_slot == 0)      scl_level = 1'b1;
                    else if (run_slot == 1) sda_level = 1'b1;
                    else if (run_slot == 2) sda_level = 1'b0;
                    else                    scl_level = 1'b0;
                end
                CMD_STOP:
                begin
                    if (run_slot == 0)      sda_level = 1'b0;
                    else if (run_slot == 1) scl_level = 1'b1;
                    else                    sda_level = 1'b1;
                end
                CMD_WRITE:
                begin
                    if (run_slot < WR_ACK_DATA)
                    begin
                        bitpos = 7 - run_slot / 4;
                        phase  = run_slot % 4;
                        if (phase == 0)      sda_level = tx_hold[bitpos];
                        else if (phase == 1) scl_level = 1'b1;
                        else if (phase == 3) scl_level = 1'b0;
                    end
                    else if (run_slot == WR_ACK_DATA)   sda_level = 1'b1;
                    else if (run_slot == WR_ACK_CLOCK)  scl_level = 1'b1;
                    else if (run_slot == WR_ACK_SAMPLE) ack_seen = ~it.port_in[sda_pin];
                    else                                scl_level = 1'b0;
                end
                CMD_READ:
                begin
                    if (run_slot == 0)
                        sda_level = 1'b1;
                    else if (run_slot <= RD_LAST_BIT)
                    begin
                        phase = (run_slot - 1) % 3;
                        if (phase == 0)      scl_level = 1'b1;
                        else if (phase == 1) rx_shift = {rx_shift[6:0], it.port_in[sda_pin]};
                        else                 scl_level = 1'b0;
                    end
                    else if (run_slot == RD_ACK_DATA)  sda_level = ~ack_pick;
                    else if (run_slot == RD_ACK_CLOCK) scl_level = 1'b1;
                    else if (run_slot == RD_ACK_LOW)   scl_level = 1'b0;
                    else if (run_slot == RD_RELEASE)   sda_level = 1'b1;
                end
                default:
                begin
                end
            endcase
            run_slot++;
            if (run_slot >= seq_length(run_cmd))
            begin
                run_cmd    = CMD_NONE;
                run_slot   = 0;
                r.done_res = 1'b1;
            end
        end
        drive = '1;
        if (!scl_level)
            drive[scl_pin] = 1'b0;
        if (!sda_level)
            drive[sda_pin] = 1'b0;
        r.port_out     = drive;
        r.busy_res     = (run_cmd != CMD_NONE);
        r.rx_byte      = rx_shift;
        r.ack_received = ack_seen;
        return r;
    endfunction

    // result side: random stalls
    initial
    begin
        int hold;
        res_ch.ready = 1'b0;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 20)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        res_item_t want;
        res_item_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (line_forecast.size() == 0)
            begin
                $error("unexpected item: port_out %h", got.port_out);
                errors++;
            end
            else
            begin
                want = line_forecast.pop_front();
                if (got.port_out !== want.port_out)
                begin
                    $error("port_out: expected %h, actual %h", want.port_out, got.port_out);
                    errors++;
                end
                if (got.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %b, actual %b", want.busy_res, got.busy_res);
                    errors++;
                end
                if (got.done_res !== want.done_res)
                begin
                    $error("done_res: expected %b, actual %b", want.done_res, got.done_res);
                    errors++;
                end
                if (got.rx_byte !== want.rx_byte)
                begin
                    $error("rx_byte: expected %h, actual %h", want.rx_byte, got.rx_byte);
                    errors++;
                end
                if (got.ack_received !== want.ack_received)
                begin
                    $error("ack_received: expected %b, actual %b",
                           want.ack_received, got.ack_received);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(input cmd_item_t it);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        do @(posedge clk); while (!cmd_ch.ready);
        line_forecast.push_back(predict_tick(it));
        ticks_sent++;
    endtask

    task automatic send_noise(input logic [OpWidth-1:0] op);
        cmd_item_t it;
        it.opcode      = op;
        it.tx_byte     = 8'($urandom);
        it.ack_to_send = 1'($urandom);
        it.port_in     = 8'($urandom);
        send_item(it);
    endtask

    // one command and all of its ticks; slave data is placed on the sample ticks
    task automatic run_command(input logic [OpWidth-1:0] op, input logic [7:0] tx,
                               input logic ack_sel, input logic [7:0] slave_byte,
                               input logic slave_ack, input bit noisy);
        cmd_item_t it;
        int        len;
        len = seq_length(op);
        if (len == 0)
            len = 1;
        for (int k = 0; k < len; k++)
        begin
            it.opcode      = (k == 0) ? op : (noisy ? 3'($urandom_range(0, 7)) : CMD_NONE);
            it.tx_byte     = (k == 0) ? tx : 8'($urandom);
            it.ack_to_send = (k == 0) ? ack_sel : 1'($urandom);
            it.port_in     = 8'($urandom);
            if (op == CMD_READ && k >= 2 && k <= RD_LAST_BIT && (k - 2) % 3 == 0)
                it.port_in[sda_pin] = slave_byte[7 - (k - 2) / 3];
            if (op == CMD_WRITE && k == WR_ACK_SAMPLE)
                it.port_in[sda_pin] = ~slave_ack;
            send_item(it);
        end
    endtask

    task automatic random_command(input logic [OpWidth-1:0] op, input bit noisy);
        run_command(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), noisy);
    endtask

    task automatic complete_sequence();
        while (run_cmd != CMD_NONE)
            send_noise(3'($urandom_range(0, 7)));
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (line_forecast.size() != 0);
    endtask

    task automatic set_pins(input logic [PinWidth-1:0] scl, input logic [PinWidth-1:0] sda);
        complete_sequence();
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CLOCK_PIN;
        cfg_data  <= scl;
        @(posedge clk);
        scl_pin = scl;
        cfg_index <= CFG_DATA_PIN;
        cfg_data  <= sda;
        @(posedge clk);
        sda_pin = sda;
        cfg_we <= 1'b0;
    endtask

    task automatic test_idle_after_reset();
        send_noise(CMD_NONE);
        for (logic [OpWidth:0] op = {1'b0, OP_UNUSED_FIRST}; op <= {1'b0, OP_UNUSED_LAST};
             op++)
            send_noise(op[OpWidth-1:0]);
    endtask

    task automatic test_start_stop();
        run_command(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
        run_command(CMD_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    endtask

    task automatic test_write_byte();
        run_command(CMD_WRITE, 8'hA5, 1'b0, 8'h00, 1'b1, 1'b0);
        run_command(CMD_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_read_byte();
        run_command(CMD_READ, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
        run_command(CMD_READ, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0);
        run_command(CMD_READ, 8'h3C, 1'b1, 8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_pin_select();
        logic [PinWidth-1:0] scl_set[4] = '{3'd7, 3'd0, 3'd3, 3'd7};
        logic [PinWidth-1:0] sda_set[4] = '{3'd0, 3'd7, 3'd3, 3'd7};
        for (int p = 0; p < 4; p++)
        begin
            set_pins(scl_set[p], sda_set[p]);
            random_command(CMD_START, 1'b0);
            random_command(CMD_WRITE, 1'b0);
            random_command(CMD_READ, 1'b0);
            random_command(CMD_STOP, 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int phase_end;
        stop_at = ticks_sent + ItemTarget;
        while (ticks_sent < stop_at)
        begin
            set_pins(3'($urandom), ($urandom_range(0, 5) == 0) ? scl_pin : 3'($urandom));
            steady    = ($urandom_range(0, 3) == 0);
            phase_end = ticks_sent + 250;
            while (ticks_sent < phase_end && ticks_sent < stop_at)
            begin
                if ($urandom_range(0, 99) < 80)
                    random_command(3'($urandom_range(CMD_START, CMD_READ)),
                                   $urandom_range(0, 3) == 0);
                else
                begin
                    send_noise(3'($urandom_range(0, 7)));
                    complete_sequence();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_CLOCK_PIN;
        cfg_data     = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        steady       = 1'b0;
        errors       = 0;
        ticks_sent   = 0;
        cycles       = 0;
        scl_pin      = 3'd0;
        sda_pin      = 3'd1;
        scl_level    = 1'b1;
        sda_level    = 1'b1;
        run_cmd      = CMD_NONE;
        run_slot     = 0;
        rx_shift     = '0;
        tx_hold      = '0;
        ack_pick     = 1'b0;
        ack_seen     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_start_stop();
        test_write_byte();
        test_read_byte();
        test_pin_select();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
